FILE: rtl/core/l2g7_pkg.sv
// Package for the Latin-1 to GSM 7-bit septet packer.
// Holds the item types, the septet constants and the character map.
// Depends on nothing.
`default_nettype none

package l2g7_pkg;

  typedef struct packed {
    logic [7:0] latin1_byte;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_octet;
    logic       last_octet;
  } out_item_t;

  // One classified character as it waits in the queue.
  typedef struct packed {
    logic       esc;
    logic [6:0] septet;
    logic       last;
  } sym_t;

  localparam logic [6:0] NoMapSeptet = 7'h3F;
  localparam logic [6:0] EscSeptet   = 7'h1B;
  localparam logic [6:0] CrSeptet    = 7'h0D;
  localparam int unsigned QueueDepth = 2;

  function automatic sym_t map_char(input logic [7:0] b, input logic last);
    sym_t s;
    s.esc    = 1'b0;
    s.septet = NoMapSeptet;
    s.last   = last;
    case (b) inside
      [8'h20:8'h23], [8'h25:8'h3F], [8'h41:8'h5A], [8'h61:8'h7A]: s.septet = b[6:0];
      8'h0A: s.septet = 7'h0A;
      8'h0C: begin s.esc = 1'b1; s.septet = 7'h0A; end
      8'h0D: s.septet = 7'h0D;
      8'h24: s.septet = 7'h02;
      8'h40: s.septet = 7'h00;
      8'h5B: begin s.esc = 1'b1; s.septet = 7'h3C; end
      8'h5C: begin s.esc = 1'b1; s.septet = 7'h2F; end
      8'h5D: begin s.esc = 1'b1; s.septet = 7'h3E; end
      8'h5E: begin s.esc = 1'b1; s.septet = 7'h14; end
      8'h5F: s.septet = 7'h11;
      8'h7B: begin s.esc = 1'b1; s.septet = 7'h28; end
      8'h7C: begin s.esc = 1'b1; s.septet = 7'h40; end
      8'h7D: begin s.esc = 1'b1; s.septet = 7'h29; end
      8'h7E: begin s.esc = 1'b1; s.septet = 7'h3D; end
      8'hA1: s.septet = 7'h40;
      8'hA3: s.septet = 7'h01;
      8'hA4: s.septet = 7'h24;
      8'hA5: s.septet = 7'h03;
      8'hA7: s.septet = 7'h5F;
      8'hBF: s.septet = 7'h60;
      8'hC4: s.septet = 7'h5B;
      8'hC5: s.septet = 7'h0E;
      8'hC6: s.septet = 7'h1C;
      8'hC7: s.septet = 7'h09;
      8'hC9: s.septet = 7'h1F;
      8'hD1: s.septet = 7'h5D;
      8'hD6: s.septet = 7'h5C;
      8'hD8: s.septet = 7'h0B;
      8'hDC: s.septet = 7'h5E;
      8'hDF: s.septet = 7'h1E;
      8'hE0: s.septet = 7'h7F;
      8'hE4: s.septet = 7'h7B;
      8'hE5: s.septet = 7'h0F;
      8'hE6: s.septet = 7'h1D;
      8'hE7: s.septet = 7'h09;
      8'hE8: s.septet = 7'h04;
      8'hE9: s.septet = 7'h05;
      8'hEC: s.septet = 7'h07;
      8'hF1: s.septet = 7'h7D;
      8'hF2: s.septet = 7'h08;
      8'hF6: s.septet = 7'h7C;
      8'hF8: s.septet = 7'h0C;
      8'hF9: s.septet = 7'h06;
      8'hFC: s.septet = 7'h7E;
      default: s.septet = NoMapSeptet;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/l2g7_front.sv
// Front end: accepts Latin-1 items, maps each through the character table
// and queues the classified symbol for the back end. Depends on l2g7_pkg.
`default_nettype none

module l2g7_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire l2g7_pkg::in_item_t in_item_i,
  output logic                    sym_valid_o,
  output l2g7_pkg::sym_t          sym_o,
  input  wire                     sym_pop_i
);
  import l2g7_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sym_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CntW'(QueueDepth));
  assign sym_valid_o = (cnt_q != '0);
  assign sym_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = sym_pop_i && sym_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= map_char(in_item_i.latin1_byte, in_item_i.last_char);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/l2g7_back.sv
// Back end: packs queued septets LSB-first into octets, inserts escapes,
// flushes the final partial octet and holds the output register.
// Depends on l2g7_pkg.
`default_nettype none

module l2g7_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 sym_valid_i,
  input  wire l2g7_pkg::sym_t sym_i,
  output logic                sym_pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output l2g7_pkg::out_item_t out_item_o
);
  import l2g7_pkg::*;

  localparam logic [1:0] PhMain  = 2'd0;
  localparam logic [1:0] PhCode  = 2'd1;
  localparam logic [1:0] PhFlush = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [6:0]  bits_q, bits_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        esc_step, slot_free, emits, step;
  logic [6:0]  sep;
  logic [14:0] acc;
  logic [6:0]  pk_bits;
  logic [2:0]  pk_cnt;
  logic [7:0]  octet;
  logic        octet_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign esc_step  = (phase_q == PhMain) && sym_i.esc;
  assign sep       = esc_step ? EscSeptet : sym_i.septet;
  assign acc       = {8'b0, bits_q} | ({8'b0, sep} << cnt_q);
  assign pk_bits   = (cnt_q == 3'd0) ? sep : acc[14:8];
  assign pk_cnt    = (cnt_q == 3'd0) ? 3'd7 : cnt_q - 3'd1;

  always_comb begin
    phase_d    = phase_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    sym_pop_o  = 1'b0;
    emits      = 1'b0;
    octet      = acc[7:0];
    octet_last = 1'b0;
    case (phase_q)
      PhFlush: begin
        emits      = 1'b1;
        octet      = (cnt_q == 3'd1) ? {CrSeptet, bits_q[0]} : {1'b0, bits_q};
        octet_last = 1'b1;
        phase_d    = PhMain;
        bits_d     = '0;
        cnt_d      = '0;
        sym_pop_o  = 1'b1;
      end
      PhMain, PhCode: begin
        emits  = (cnt_q != 3'd0);
        bits_d = pk_bits;
        cnt_d  = pk_cnt;
        if (esc_step) begin
          phase_d = PhCode;
        end else if (sym_i.last && pk_cnt != 3'd0) begin
          phase_d = PhFlush;
        end else begin
          octet_last = sym_i.last;
          phase_d    = PhMain;
          sym_pop_o  = 1'b1;
        end
      end
      default: begin
        phase_d = PhMain;
      end
    endcase
    step = sym_valid_i && (!emits || slot_free);
    if (!step) begin
      phase_d   = phase_q;
      bits_d    = bits_q;
      cnt_d     = cnt_q;
      sym_pop_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMain;
      bits_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      cnt_q   <= cnt_d;
      if (step && emits) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emits) begin
      out_q.packed_octet <= octet;
      out_q.last_octet   <= octet_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/latin1_to_gsm7_septet_packer.sv
// Top level of the Latin-1 to GSM 7-bit septet packer.
// Instantiates l2g7_front and l2g7_back; depends on l2g7_pkg.
//
// The input channel takes one Latin-1 character per item with a flag that
// marks the last character of a message. The output channel gives packed
// octets, the final octet of a message flagged. Both use valid and ready.
// An accepted item is mapped and placed in a two-entry queue in the same
// cycle; octets it completes then pass through the output register. The
// packer handles one septet step per cycle while the receiver keeps up:
// a plain character takes one step, an escaped character two, and a last
// character with a partial octet left over one more for the flush. Plain
// characters thus sustain one item per cycle. Any character completing no
// octet gives no output item. When the receiver stalls, the output register
// holds its octet, the packer waits, and the queue fills; input ready drops
// when it is full. Reset empties the queue, clears the output and the
// pending bits, and starts a new message.
`default_nettype none

module latin1_to_gsm7_septet_packer (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire l2g7_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output l2g7_pkg::out_item_t     out_item_o
);
  import l2g7_pkg::*;

  logic sym_valid;
  logic sym_pop;
  sym_t sym;

  l2g7_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .sym_valid_o (sym_valid),
    .sym_o       (sym),
    .sym_pop_i   (sym_pop)
  );

  l2g7_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_valid_i (sym_valid),
    .sym_i       (sym),
    .sym_pop_o   (sym_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
